>>> rtl/core/fxp_pkg.sv
`default_nettype none

package fxp_pkg;

    localparam int MAX_LEN     = 60;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int STORE_DEPTH = 64;
    localparam int BANK_CNT    = 2;
    localparam int MEM_ADDR_W  = $clog2(STORE_DEPTH * BANK_CNT);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hBB;
    localparam logic [BYTE_W-1:0] LEN_MIN      = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_MAX      = BYTE_W'(MAX_LEN);
    localparam logic [IDX_W-1:0]  POS_CMD      = 6'd3;
    localparam logic [IDX_W-1:0]  POS_PAYLOAD  = 6'd4;

    // register index decode on paddr[2]
    localparam logic REG_HEADER = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [IDX_W-1:0]  plen;
        logic              bank;
    } desc_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     data;
    } wr_t;

endpackage

`default_nettype wire

>>> rtl/core/fxp_if.sv
`default_nettype none

interface fxp_byte_if;
    import fxp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fxp_result_if;
    import fxp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] command;
    logic [IDX_W-1:0]  payload_len;
    logic              has_data;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output command, output payload_len, output has_data,
                    output byte_index, output data_byte, output last, input ready);
    modport sink   (input valid, input command, input payload_len, input has_data,
                    input byte_index, input data_byte, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/xor_checked_frame_parser_unit.sv
`default_nettype none

// Frame parser for a length-prefixed, XOR-checked byte stream. The front end
// takes one rx word per cycle, hunts for the header byte, checks the length
// (3 to 60) and the XOR over the whole frame, and writes payload bytes into a
// two-bank store. A good frame posts a descriptor into a two-entry queue; the
// back end replays it as one result per payload byte (one result with
// has_data low for an empty payload), last marked on the final one. A frame of
// length L is L+2 rx words long; replay picks up the descriptor, then makes
// each result by a store read and then the output register, or by the
// output step alone for an empty payload. rx stalls only while two good
// frames sit in the queue, until the older one has been fully replayed. The
// header byte register sits at address 0 of the APB port and resets to 0xBB.
module xor_checked_frame_parser_unit
    import fxp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    fxp_byte_if.sink         rx,
    fxp_result_if.source     res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [BYTE_W-1:0] header_reg;
    logic              push;
    logic              pop;
    logic              q_valid;
    logic              q_full;
    desc_t             push_data;
    desc_t             head;
    wr_t               wr;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEADER) ? {24'd0, header_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER)
        begin
            header_reg <= pwdata[BYTE_W-1:0];
        end
    end

    fxp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .header    (header_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data),
        .wr        (wr)
    );

    fxp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    fxp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .head    (head),
        .q_valid (q_valid),
        .pop     (pop),
        .res     (res)
    );

endmodule

`default_nettype wire

>>> rtl/core/fxp_front.sv
`default_nettype none

module fxp_front
    import fxp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    fxp_byte_if.sink               rx,
    input  wire logic [BYTE_W-1:0] header,
    input  wire logic              q_full,
    output logic                   push,
    output desc_t                  push_data,
    output wr_t                    wr
);

    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  flen_reg, flen_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic              bank_reg, bank_next;
    logic              take;
    logic              at_check;
    logic [IDX_W-1:0]  slot;

    assign rx.ready = !q_full;
    assign take     = rx.valid && rx.ready;
    assign at_check = ({1'b0, count_reg} == ({1'b0, flen_reg} + 7'd1));
    assign slot     = count_reg - POS_PAYLOAD;

    always_comb
    begin
        count_next = count_reg;
        flen_next  = flen_reg;
        xor_next   = xor_reg;
        cmd_next   = cmd_reg;
        bank_next  = bank_reg;
        push       = 1'b0;
        wr.en      = 1'b0;
        wr.addr    = {bank_reg, slot};
        wr.data    = rx.rx_byte;
        if (take)
        begin
            if (count_reg == '0)
            begin
                if (rx.rx_byte == header)
                begin
                    xor_next   = rx.rx_byte;
                    count_next = 6'd1;
                end
            end
            else if (count_reg == 6'd1)
            begin
                // drop a bad length and hunt again from the next word
                if (rx.rx_byte < LEN_MIN || rx.rx_byte > LEN_MAX)
                begin
                    count_next = '0;
                end
                else
                begin
                    flen_next  = rx.rx_byte[IDX_W-1:0];
                    xor_next   = xor_reg ^ rx.rx_byte;
                    count_next = 6'd2;
                end
            end
            else if (at_check)
            begin
                count_next = '0;
                if (xor_reg == rx.rx_byte)
                begin
                    push      = 1'b1;
                    bank_next = !bank_reg;
                end
            end
            else
            begin
                if (count_reg == POS_CMD)
                begin
                    cmd_next = rx.rx_byte;
                end
                else if (count_reg >= POS_PAYLOAD)
                begin
                    wr.en = 1'b1;
                end
                xor_next   = xor_reg ^ rx.rx_byte;
                count_next = count_reg + 6'd1;
            end
        end
    end

    assign push_data.command = cmd_reg;
    assign push_data.plen    = flen_reg - IDX_W'(LEN_MIN);
    assign push_data.bank    = bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flen_reg  <= '0;
            xor_reg   <= '0;
            cmd_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flen_reg  <= flen_next;
            xor_reg   <= xor_next;
            cmd_reg   <= cmd_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fxp_queue.sv
`default_nettype none

module fxp_queue
    import fxp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_data,
    input  wire logic  pop,
    output desc_t      head,
    output logic       not_empty,
    output logic       full
);

    desc_t      entry_reg [BANK_CNT];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fxp_back.sv
`default_nettype none

module fxp_back
    import fxp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire wr_t   wr,
    input  wire desc_t head,
    input  wire logic  q_valid,
    output logic       pop,
    fxp_result_if.source res
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_SHOW = 2'd2;

    logic [BYTE_W-1:0] mem [STORE_DEPTH * BANK_CNT];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              has_data;
    logic              is_last;

    assign has_data = (head.plen != '0);
    assign is_last  = !has_data || ((idx_reg + 6'd1) == head.plen);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_READ)
        begin
            rd_data_reg <= mem[{head.bank, idx_reg}];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    idx_next   = '0;
                    state_next = has_data ? B_READ : B_SHOW;
                end
            end
            B_READ:
            begin
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (res.ready)
                begin
                    if (is_last)
                    begin
                        pop        = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign res.valid       = (state_reg == B_SHOW);
    assign res.command     = head.command;
    assign res.payload_len = head.plen;
    assign res.has_data    = has_data;
    assign res.byte_index  = idx_reg;
    assign res.data_byte   = has_data ? rd_data_reg : '0;
    assign res.last        = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fxp_checker.sv
`default_nettype none

module fxp_checker
    import fxp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [BYTE_W-1:0] command,
    input wire logic [IDX_W-1:0]  payload_len,
    input wire logic              has_data,
    input wire logic [IDX_W-1:0]  byte_index,
    input wire logic              last
);

    // hold a stalled result word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(command) && $stable(byte_index))
        else $error("result word changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !has_data |-> last && payload_len == '0 && byte_index == '0)
        else $error("empty frame result malformed");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_data |-> byte_index < payload_len)
        else $error("byte index beyond payload length");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_data |-> last == (byte_index + 6'd1 == payload_len))
        else $error("last flag misplaced");

endmodule

bind xor_checked_frame_parser_unit fxp_checker u_fxp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .command     (res.command),
    .payload_len (res.payload_len),
    .has_data    (res.has_data),
    .byte_index  (res.byte_index),
    .last        (res.last)
);

`default_nettype wire

>>> dv/fxp_replay_monitor.sv
module fxp_replay_monitor
    import fxp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    fxp_byte_if              rx,
    fxp_result_if            res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               words_owed,
    output int               mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [IDX_W-1:0]  payload_len;
        logic              has_data;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } replay_word_t;

    replay_word_t      replay_q[$];
    logic [BYTE_W-1:0] hdr_reg;
    logic [BYTE_W-1:0] run_xor;
    logic [BYTE_W-1:0] cmd_hold;
    logic [IDX_W-1:0]  pos_cnt;
    logic [IDX_W-1:0]  frame_len;
    logic [BYTE_W-1:0] payload_mem [STORE_DEPTH];

    // Advance the frame parse by one rx word; queue the replay of a good frame.
    task automatic parse_rx_word(input logic [BYTE_W-1:0] b);
        replay_word_t     w;
        logic [IDX_W-1:0] plen;
        int               i;
        if (pos_cnt == 0) begin
            if (b == hdr_reg) begin
                run_xor = b;
                pos_cnt = 1;
            end
        end
        else if (pos_cnt == 1) begin
            // drop a bad length byte without retrying it as a header
            if (b < LEN_MIN || b > LEN_MAX)
                pos_cnt = 0;
            else begin
                frame_len = b[IDX_W-1:0];
                run_xor   = run_xor ^ b;
                pos_cnt   = 2;
            end
        end
        else if (pos_cnt == frame_len + 6'd1) begin
            pos_cnt = 0;
            if (run_xor == b) begin
                plen = frame_len - IDX_W'(LEN_MIN);
                if (plen == 0) begin
                    w         = '0;
                    w.command = cmd_hold;
                    w.last    = 1'b1;
                    replay_q  = {replay_q, w};
                end
                else begin
                    for (i = 0; i < plen; i++) begin
                        w.command     = cmd_hold;
                        w.payload_len = plen;
                        w.has_data    = 1'b1;
                        w.byte_index  = IDX_W'(i);
                        w.data_byte   = payload_mem[IDX_W'(i)];
                        w.last        = (i == plen - 1);
                        replay_q      = {replay_q, w};
                    end
                end
            end
        end
        else begin
            if (pos_cnt == POS_CMD)
                cmd_hold = b;
            else if (pos_cnt >= POS_PAYLOAD)
                payload_mem[pos_cnt - POS_PAYLOAD] = b;
            run_xor = run_xor ^ b;
            pos_cnt = pos_cnt + 6'd1;
        end
    endtask

    task automatic cmp_field(input string fname, input logic [31:0] expv,
                             input logic [31:0] actv);
        if (expv !== actv) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, expv, actv);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        replay_word_t w;
        if (!rst_n) begin
            replay_q.delete();
            hdr_reg    = HEADER_RESET;
            run_xor    = '0;
            cmd_hold   = '0;
            pos_cnt    = '0;
            frame_len  = '0;
            words_owed = 0;
            mismatches = 0;
        end
        else begin
            if (res.valid && res.ready) begin
                if (replay_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected, command %0d index %0d",
                             $time, res.command, res.byte_index);
                end
                else begin
                    w = replay_q.pop_front();
                    cmp_field("command", w.command, res.command);
                    cmp_field("payload_len", w.payload_len, res.payload_len);
                    cmp_field("has_data", w.has_data, res.has_data);
                    cmp_field("byte_index", w.byte_index, res.byte_index);
                    cmp_field("data_byte", w.data_byte, res.data_byte);
                    cmp_field("last", w.last, res.last);
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER)
                hdr_reg = pwdata[BYTE_W-1:0];
            if (rx.valid && rx.ready)
                parse_rx_word(rx.rx_byte);
            words_owed = replay_q.size();
        end
    end

endmodule

>>> dv/tb_top.sv
module tb_top;
    import fxp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] HEADER_ADDR   = 3'd0;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         HOLD_CYCLES   = 600;
    localparam int         PHASE_WORDS   = 75;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          src_idle_pct;
    int          sink_idle_pct;
    int          hold_asked;
    int          hold_done;
    int          hold_left;
    int          words_owed;
    int          mismatches;
    logic [7:0]  cur_hdr;

    fxp_byte_if   rx_if();
    fxp_result_if res_if();

    xor_checked_frame_parser_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fxp_replay_monitor mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_if),
        .res        (res_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .words_owed (words_owed),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs on request.
    initial
    begin
        res_if.ready = 1'b0;
        hold_done    = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_asked != hold_done)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
    endtask

    // Drop valid, wait out every owed result, then let the front end go quiet.
    task automatic settle();
        rx_if.valid <= 1'b0;
        do @(posedge clk); while (words_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_header(input logic [7:0] h);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HEADER_ADDR;
        pwdata  <= {24'd0, h};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_hdr = h;
    endtask

    task automatic send_frame(input int len, input bit bad_check);
        logic [7:0] chk;
        logic [7:0] b;
        int         k;
        chk = cur_hdr ^ 8'(len);
        send_byte(cur_hdr);
        send_byte(8'(len));
        // address, command and payload
        for (k = 0; k < len - 1; k++)
        begin
            b   = 8'($urandom_range(0, 255));
            chk = chk ^ b;
            send_byte(b);
        end
        if (bad_check)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    task automatic run_phase(input int goal);
        int sent;
        int pick;
        int len;
        int n;
        sent = 0;
        while (sent < goal)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? int'(LEN_MAX) : $urandom_range(3, 12);
            if (pick < 70)
            begin
                send_frame(len, 1'b0);
                sent += len + 2;
            end
            else if (pick < 82)
            begin
                send_frame(len, 1'b1);
                sent += len + 2;
            end
            else if (pick < 91)
            begin
                send_byte(cur_hdr);
                if ($urandom_range(0, 1))
                    send_byte(8'($urandom_range(0, 2)));
                else
                    send_byte(8'($urandom_range(int'(LEN_MAX) + 1, 255)));
                sent += 2;
            end
            else
            begin
                // line noise between frames
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                sent += n;
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cur_hdr       = HEADER_RESET;
        hold_asked    = 0;
        src_idle_pct  = 34;
        sink_idle_pct = 74;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty payload
        send_frame(3, 1'b0);
        // bad lengths at both edges, zero, and the header byte itself as length
        send_byte(cur_hdr);
        send_byte(8'd2);
        send_byte(cur_hdr);
        send_byte(8'(int'(LEN_MAX) + 1));
        send_byte(cur_hdr);
        send_byte(8'h00);
        send_byte(cur_hdr);
        send_byte(cur_hdr);
        send_frame(4, 1'b1);
        // header moves mid-frame; the frame in flight still completes
        send_byte(cur_hdr);
        send_byte(8'd4);
        send_byte(8'h00);
        set_header(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(HEADER_RESET ^ 8'd4 ^ 8'h00 ^ 8'hFF ^ 8'h00);

        settle();
        run_phase(PHASE_WORDS);

        set_header(8'hFF);
        src_idle_pct  = 74;
        sink_idle_pct = 34;
        run_phase(PHASE_WORDS);

        set_header(8'($urandom_range(1, 254)));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // hold off results while frames keep coming, so rx backs up
        hold_asked++;
        repeat (5) send_frame($urandom_range(3, 8), 1'b0);
        run_phase(PHASE_WORDS);

        settle();
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
